// ===== rtl/gaussian_nll_loss_and_gradient_top_assert.svh =====
// assertion macros for the rtl files, included by gnll_back
`ifndef GAUSSIAN_NLL_LOSS_AND_GRADIENT_TOP_ASSERT_SVH
`define GAUSSIAN_NLL_LOSS_AND_GRADIENT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define GNLL_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gnll implication check failed");
`define GNLL_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("gnll invariant check failed");
`else
`define GNLL_ASSERT_IMPLY(lbl, ante, cons)
`define GNLL_ASSERT_ALWAYS(lbl, cond)
`endif
`endif

// ===== rtl/gnll_pkg.sv =====
package gnll_pkg;

	localparam int DATA_WIDTH_DEF    = 32;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int ACCUM_WIDTH_DEF   = 48;

	localparam int QDEPTH    = 2;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRAD_SEL = 2'd0,
		REG_BETA     = 2'd1,
		REG_PROP_EN  = 2'd2
	} reg_idx_t;

	// ln2 and 0.5*ln(2*pi) with 32 fraction bits
	localparam logic [63:0] LN2_Q32         = 64'd2977044472;
	localparam logic [63:0] HALF_LN_2PI_Q32 = 64'd3946810947;
	localparam logic [63:0] CAP64           = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic grad_sel;
		logic prop_en;
	} cfg_flags_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic bad;
	} item_ctl_t;

	typedef struct packed {
		logic        err;
		logic [63:0] val;
	} sat_t;

	function automatic logic signed [65:0] ext66(input logic [63:0] a);
		return $signed({{2{a[63]}}, a});
	endfunction

	function automatic logic [63:0] mag64(input logic [63:0] a);
		return a[63] ? (~a + 64'd1) : a;
	endfunction

	// clamp a wide sum to +-cap
	function automatic sat_t sat_sum(input logic signed [65:0] v, input logic [63:0] cap);
		sat_t r;
		logic signed [65:0] c;
		c = $signed({2'b00, cap});
		r.err = 1'b0;
		r.val = v[63:0];
		if (v > c) begin
			r.err = 1'b1;
			r.val = cap;
		end else if (v < -c) begin
			r.err = 1'b1;
			r.val = ~cap + 64'd1;
		end
		return r;
	endfunction

	// unsigned magnitude to signed 64, clamped to +-(2^63-1)
	function automatic sat_t sat_mag(input logic [127:0] m, input logic neg);
		sat_t r;
		logic [63:0] v;
		v = m[63:0];
		r.err = 1'b0;
		if (m[127:63] != '0) begin
			r.err = 1'b1;
			v = CAP64;
		end
		r.val = neg ? (~v + 64'd1) : v;
		return r;
	endfunction

endpackage

// ===== rtl/gnll_mul.sv =====
module gnll_mul import gnll_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic [127:0] prod,
	output logic         done
);

	logic [63:0]  a_q, b_q;
	logic [127:0] prod_q;
	logic [1:0]   cnt_q;
	logic         busy_q, done_q;
	logic [31:0]  a_h, b_h;
	logic [63:0]  pp;
	logic [127:0] pp_sh;

	// one 32x32 partial product a cycle
	always_comb begin
		a_h = cnt_q[1] ? a_q[63:32] : a_q[31:0];
		b_h = cnt_q[0] ? b_q[63:32] : b_q[31:0];
		pp  = 64'(a_h) * 64'(b_h);
		case (cnt_q)
			2'd0:    pp_sh = 128'(pp);
			2'd3:    pp_sh = 128'(pp) << 64;
			default: pp_sh = 128'(pp) << 32;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			prod_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q    <= a;
				b_q    <= b;
				prod_q <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				prod_q <= prod_q + pp_sh;
				cnt_q  <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign prod = prod_q;
	assign done = done_q;

endmodule

// ===== rtl/gnll_div.sv =====
module gnll_div import gnll_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [63:0]                 num,
	input  logic [63:0]                 den,
	output logic [64+FRACTION_BITS-1:0] quo,
	output logic                        done
);

	localparam int NB   = 64 + FRACTION_BITS;
	localparam int CNTW = $clog2(NB + 1);

	logic [NB-1:0]   num_q, quo_q;
	logic [63:0]     rem_q, den_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q, done_q;
	logic [64:0]     rem_sh, rem_nx;
	logic            ge;

	// restoring division, one quotient bit a cycle
	always_comb begin
		rem_sh = {rem_q, num_q[NB-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q  <= NB'(num) << FRACTION_BITS;
				den_q  <= den;
				rem_q  <= '0;
				quo_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				num_q <= num_q << 1;
				rem_q <= rem_nx[63:0];
				quo_q <= {quo_q[NB-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(NB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

// ===== rtl/gnll_front.sv =====
module gnll_front import gnll_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] mean_value,
	input  logic signed [DATA_WIDTH-1:0] deviation_value,
	input  logic signed [DATA_WIDTH-1:0] target_value,
	input  logic signed [DATA_WIDTH-1:0] earlier_gradient,
	input  logic                         last_element,
	input  logic                         take,
	output item_ctl_t                    f_ctl,
	output logic signed [DATA_WIDTH-1:0] f_mean,
	output logic signed [DATA_WIDTH-1:0] f_dev,
	output logic signed [DATA_WIDTH-1:0] f_target,
	output logic signed [DATA_WIDTH-1:0] f_grad
);

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	logic signed [DATA_WIDTH-1:0] mean_q [QDEPTH];
	logic signed [DATA_WIDTH-1:0] dev_q  [QDEPTH];
	logic signed [DATA_WIDTH-1:0] tgt_q  [QDEPTH];
	logic signed [DATA_WIDTH-1:0] grad_q [QDEPTH];
	logic [QDEPTH-1:0]            last_q, bad_q;
	logic [PW-1:0]                wr_q, rd_q;
	logic [CW-1:0]                cnt_q;
	logic                         push, bad;

	assign in_stall = (cnt_q == CW'(QDEPTH));
	assign push     = in_valid && !in_stall;
	// sigma not positive is replaced by one lsb
	assign bad      = (deviation_value <= 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (take) begin
				rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (take && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mean_q[wr_q] <= mean_value;
			dev_q[wr_q]  <= bad ? DATA_WIDTH'(1) : deviation_value;
			tgt_q[wr_q]  <= target_value;
			grad_q[wr_q] <= earlier_gradient;
			last_q[wr_q] <= last_element;
			bad_q[wr_q]  <= bad;
		end
	end

	always_comb begin
		f_ctl.valid = (cnt_q != '0);
		f_ctl.last  = last_q[rd_q];
		f_ctl.bad   = bad_q[rd_q];
		f_mean      = mean_q[rd_q];
		f_dev       = dev_q[rd_q];
		f_target    = tgt_q[rd_q];
		f_grad      = grad_q[rd_q];
	end

endmodule

// ===== rtl/gnll_back.sv =====
module gnll_back import gnll_pkg::*; #(
	parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int ACCUM_WIDTH   = ACCUM_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  item_ctl_t                     f_ctl,
	input  logic signed [DATA_WIDTH-1:0]  f_mean,
	input  logic signed [DATA_WIDTH-1:0]  f_dev,
	input  logic signed [DATA_WIDTH-1:0]  f_target,
	input  logic signed [DATA_WIDTH-1:0]  f_grad,
	output logic                          take,
	input  cfg_flags_t                    cfg,
	input  logic signed [DATA_WIDTH-1:0]  beta,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [DATA_WIDTH-1:0]  gradient_out,
	output logic signed [ACCUM_WIDTH-1:0] loss_total,
	output logic                          final_flag,
	output logic                          range_error
);

`include "gaussian_nll_loss_and_gradient_top_assert.svh"

	localparam int FB  = FRACTION_BITS;
	localparam int NB  = 64 + FB;
	localparam int SCW = $clog2(FB);
	localparam logic [63:0] HALF = (HALF_LN_2PI_Q32 + (64'd1 << (31 - FB))) >> (32 - FB);
	localparam logic [63:0] AMAX = (64'd1 << (ACCUM_WIDTH - 1)) - 64'd1;
	localparam logic [63:0] DMAX = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
	localparam logic [63:0] DMIN = ~DMAX;
	localparam logic [ACCUM_WIDTH-1:0] ACC_MIN = ~AMAX[ACCUM_WIDTH-1:0];

	typedef enum logic [4:0] {
		ST_IDLE, ST_LOAD, ST_DQ_GO, ST_DQ_WAIT, ST_NORM, ST_SQ_GO, ST_SQ_WAIT,
		ST_LN_GO, ST_LN_WAIT, ST_QQ_GO, ST_QQ_WAIT, ST_ACC, ST_BP_GO, ST_BP_WAIT,
		ST_G_GO, ST_G_WAIT, ST_IV_GO, ST_IV_WAIT, ST_R3_GO, ST_R3_WAIT,
		ST_CLAMP, ST_OUT
	} state_t;

	state_t st_q;
	logic [63:0] mu_q, x_q, g0_q, s_q;
	logic [63:0] d_q, q_q, m_q, term_q, r_q, bp_q, tmp_q, grad_q;
	logic [5:0]  p_q;
	logic [FB-1:0]  frac_q;
	logic [SCW-1:0] cnt_q;
	logic        last_q, err_q, mul_neg_q, div_neg_q;
	logic signed [ACCUM_WIDTH-1:0] acc_q, tot_q;

	logic                 out_valid_q, final_q, rerr_q;
	logic signed [DATA_WIDTH-1:0]  gout_q;
	logic signed [ACCUM_WIDTH-1:0] lout_q;

	logic         mul_start, mul_done, div_start, div_done;
	logic [63:0]  mul_a, mul_b, div_num, beta64, l2, sq, m_nx;
	logic [127:0] mul_prod;
	logic [NB-1:0] div_quo;
	sat_t d_s, dq_s, m_fb, m_fb1, m_32, t1_s, t2_s, acc_s, qb_s, r3_s;

	gnll_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	gnll_div #(.FRACTION_BITS(FB)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (s_q),
		.quo    (div_quo),
		.done   (div_done)
	);

	always_comb begin
		beta64 = 64'(beta);
		// log2 estimate: integer part from leading one, fraction from squarings
		l2     = ((64'(p_q) - 64'(FB)) << FB) + 64'(frac_q);
		sq     = mul_prod[125:62];
		m_nx   = sq[63] ? (sq >> 1) : sq;

		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (st_q)
			ST_SQ_GO: begin
				mul_start = 1'b1;
				mul_a     = m_q;
				mul_b     = m_q;
			end
			ST_LN_GO: begin
				mul_start = 1'b1;
				mul_a     = mag64(l2);
				mul_b     = LN2_Q32;
			end
			ST_QQ_GO: begin
				mul_start = 1'b1;
				mul_a     = mag64(q_q);
				mul_b     = mag64(q_q);
			end
			ST_BP_GO: begin
				mul_start = 1'b1;
				mul_a     = mag64(beta64);
				mul_b     = mag64(g0_q);
			end
			default: ;
		endcase

		div_start = 1'b0;
		div_num   = '0;
		case (st_q)
			ST_DQ_GO: begin
				div_start = 1'b1;
				div_num   = mag64(d_q);
			end
			ST_G_GO: begin
				div_start = 1'b1;
				div_num   = mag64(q_q);
			end
			ST_IV_GO: begin
				div_start = 1'b1;
				div_num   = 64'd1 << FB;
			end
			ST_R3_GO: begin
				div_start = 1'b1;
				div_num   = r_q;
			end
			default: ;
		endcase

		d_s   = sat_sum(ext66(mu_q) - ext66(x_q), CAP64);
		dq_s  = sat_mag(128'(div_quo), div_neg_q);
		m_fb  = sat_mag(mul_prod >> FB, mul_neg_q);
		m_fb1 = sat_mag(mul_prod >> (FB + 1), 1'b0);
		m_32  = sat_mag(mul_prod >> 32, mul_neg_q);
		t1_s  = sat_sum(ext66(m_32.val) + ext66(HALF), CAP64);
		t2_s  = sat_sum(ext66(term_q) + ext66(m_fb1.val), CAP64);
		acc_s = sat_sum(66'(acc_q) + ext66(term_q), AMAX);
		qb_s  = sat_sum(ext66(dq_s.val) + ext66(bp_q), CAP64);
		r3_s  = sat_sum(ext66(tmp_q) - ext66(dq_s.val), CAP64);
	end

	assign take = (st_q == ST_IDLE) && f_ctl.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			mu_q        <= '0;
			x_q         <= '0;
			g0_q        <= '0;
			s_q         <= '0;
			d_q         <= '0;
			q_q         <= '0;
			m_q         <= '0;
			term_q      <= '0;
			r_q         <= '0;
			bp_q        <= '0;
			tmp_q       <= '0;
			grad_q      <= '0;
			p_q         <= '0;
			frac_q      <= '0;
			cnt_q       <= '0;
			last_q      <= 1'b0;
			err_q       <= 1'b0;
			mul_neg_q   <= 1'b0;
			div_neg_q   <= 1'b0;
			acc_q       <= '0;
			tot_q       <= '0;
			out_valid_q <= 1'b0;
			final_q     <= 1'b0;
			rerr_q      <= 1'b0;
			gout_q      <= '0;
			lout_q      <= '0;
		end else begin
			// in ST_OUT the output register is reloaded below instead
			if (out_valid_q && !out_stall && st_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (f_ctl.valid) begin
						mu_q   <= 64'(f_mean);
						x_q    <= 64'(f_target);
						g0_q   <= 64'(f_grad);
						s_q    <= 64'(f_dev);
						last_q <= f_ctl.last;
						err_q  <= f_ctl.bad;
						grad_q <= '0;
						st_q   <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					d_q   <= d_s.val;
					err_q <= err_q | d_s.err;
					st_q  <= ST_DQ_GO;
				end
				ST_DQ_GO: begin
					div_neg_q <= d_q[63];
					st_q      <= ST_DQ_WAIT;
				end
				ST_DQ_WAIT: begin
					if (div_done) begin
						q_q   <= dq_s.val;
						err_q <= err_q | dq_s.err;
						m_q   <= s_q;
						p_q   <= 6'd62;
						st_q  <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (m_q[62]) begin
						cnt_q  <= '0;
						frac_q <= '0;
						st_q   <= ST_SQ_GO;
					end else begin
						m_q <= m_q << 1;
						p_q <= p_q - 6'd1;
					end
				end
				ST_SQ_GO: begin
					st_q <= ST_SQ_WAIT;
				end
				ST_SQ_WAIT: begin
					if (mul_done) begin
						m_q    <= m_nx;
						frac_q <= {frac_q[FB-2:0], sq[63]};
						cnt_q  <= cnt_q + 1'b1;
						st_q   <= (cnt_q == SCW'(FB - 1)) ? ST_LN_GO : ST_SQ_GO;
					end
				end
				ST_LN_GO: begin
					mul_neg_q <= l2[63];
					st_q      <= ST_LN_WAIT;
				end
				ST_LN_WAIT: begin
					if (mul_done) begin
						term_q <= t1_s.val;
						err_q  <= err_q | m_32.err | t1_s.err;
						st_q   <= ST_QQ_GO;
					end
				end
				ST_QQ_GO: begin
					mul_neg_q <= 1'b0;
					st_q      <= ST_QQ_WAIT;
				end
				ST_QQ_WAIT: begin
					if (mul_done) begin
						term_q <= t2_s.val;
						r_q    <= m_fb.val;
						// q*q at full scale only matters for the sigma gradient
						err_q  <= err_q | m_fb1.err | t2_s.err
							| (cfg.prop_en & cfg.grad_sel & m_fb.err);
						st_q   <= ST_ACC;
					end
				end
				ST_ACC: begin
					err_q <= err_q | acc_s.err;
					if (last_q) begin
						tot_q <= ACCUM_WIDTH'(acc_s.val);
						acc_q <= '0;
					end else begin
						tot_q <= '0;
						acc_q <= ACCUM_WIDTH'(acc_s.val);
					end
					st_q <= cfg.prop_en ? ST_BP_GO : ST_OUT;
				end
				ST_BP_GO: begin
					mul_neg_q <= beta64[63] ^ g0_q[63];
					st_q      <= ST_BP_WAIT;
				end
				ST_BP_WAIT: begin
					if (mul_done) begin
						bp_q  <= m_fb.val;
						err_q <= err_q | m_fb.err;
						st_q  <= cfg.grad_sel ? ST_IV_GO : ST_G_GO;
					end
				end
				ST_G_GO: begin
					div_neg_q <= q_q[63];
					st_q      <= ST_G_WAIT;
				end
				ST_G_WAIT: begin
					if (div_done) begin
						grad_q <= qb_s.val;
						err_q  <= err_q | dq_s.err | qb_s.err;
						st_q   <= ST_CLAMP;
					end
				end
				ST_IV_GO: begin
					div_neg_q <= 1'b0;
					st_q      <= ST_IV_WAIT;
				end
				ST_IV_WAIT: begin
					if (div_done) begin
						tmp_q <= qb_s.val;
						err_q <= err_q | dq_s.err | qb_s.err;
						st_q  <= ST_R3_GO;
					end
				end
				ST_R3_GO: begin
					div_neg_q <= 1'b0;
					st_q      <= ST_R3_WAIT;
				end
				ST_R3_WAIT: begin
					if (div_done) begin
						grad_q <= r3_s.val;
						err_q  <= err_q | dq_s.err | r3_s.err;
						st_q   <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					if ($signed(grad_q) > $signed(DMAX)) begin
						grad_q <= DMAX;
						err_q  <= 1'b1;
					end else if ($signed(grad_q) < $signed(DMIN)) begin
						grad_q <= DMIN;
						err_q  <= 1'b1;
					end
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						gout_q      <= DATA_WIDTH'(grad_q);
						lout_q      <= tot_q;
						final_q     <= last_q;
						rerr_q      <= err_q;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign gradient_out = gout_q;
	assign loss_total   = lout_q;
	assign final_flag   = final_q;
	assign range_error  = rerr_q;

	`GNLL_ASSERT_IMPLY(a_take_idle, take, f_ctl.valid && st_q == ST_IDLE)
	`GNLL_ASSERT_IMPLY(a_loss_only_final, out_valid && !final_flag, loss_total == '0)
	`GNLL_ASSERT_ALWAYS(a_acc_symmetric, acc_q != ACC_MIN)
	`GNLL_ASSERT_IMPLY(a_mul_done_waited, mul_done,
		st_q == ST_SQ_WAIT || st_q == ST_LN_WAIT || st_q == ST_QQ_WAIT || st_q == ST_BP_WAIT)

endmodule

// ===== rtl/gaussian_nll_loss_and_gradient_top.sv =====
// channel   direction  handshake                fields
// input     in         in_valid / in_stall      mean, deviation, target, earlier grad, last
// output    out        out_valid / out_stall    gradient_out, loss_total, final_flag, range_error
// config    in         cfg_we                   cfg_index, cfg_data
//
// one word at a time in the back end; the time per word depends on the gradient selected
// and on propagation, and varies with the normalize shift, longest for small sigma; it is
// set by the bit-serial divider and the shared multiplier, run once per fraction bit for
// the squarings of the log
// the input queue holds two words, so input is taken while a result waits on out_stall
// reset clears the loss sum and the registers (propagate_enable comes up set)
module gaussian_nll_loss_and_gradient_top import gnll_pkg::*; #(
	parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int ACCUM_WIDTH   = ACCUM_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [DATA_WIDTH-1:0]  mean_value,
	input  logic signed [DATA_WIDTH-1:0]  deviation_value,
	input  logic signed [DATA_WIDTH-1:0]  target_value,
	input  logic signed [DATA_WIDTH-1:0]  earlier_gradient,
	input  logic                          last_element,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [DATA_WIDTH-1:0]  gradient_out,
	output logic signed [ACCUM_WIDTH-1:0] loss_total,
	output logic                          final_flag,
	output logic                          range_error,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [DATA_WIDTH-1:0]         cfg_data
);

	logic                         grad_sel_q, prop_en_q;
	logic signed [DATA_WIDTH-1:0] beta_q;
	cfg_flags_t                   cfg;
	item_ctl_t                    f_ctl;
	logic                         take;
	logic signed [DATA_WIDTH-1:0] f_mean, f_dev, f_target, f_grad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grad_sel_q <= 1'b0;
			beta_q     <= '0;
			prop_en_q  <= 1'b1;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_GRAD_SEL: grad_sel_q <= cfg_data[0];
				REG_BETA:     beta_q     <= $signed(cfg_data);
				REG_PROP_EN:  prop_en_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.grad_sel = grad_sel_q;
	assign cfg.prop_en  = prop_en_q;

	gnll_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.mean_value       (mean_value),
		.deviation_value  (deviation_value),
		.target_value     (target_value),
		.earlier_gradient (earlier_gradient),
		.last_element     (last_element),
		.take             (take),
		.f_ctl            (f_ctl),
		.f_mean           (f_mean),
		.f_dev            (f_dev),
		.f_target         (f_target),
		.f_grad           (f_grad)
	);

	gnll_back #(
		.DATA_WIDTH    (DATA_WIDTH),
		.FRACTION_BITS (FRACTION_BITS),
		.ACCUM_WIDTH   (ACCUM_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.f_ctl        (f_ctl),
		.f_mean       (f_mean),
		.f_dev        (f_dev),
		.f_target     (f_target),
		.f_grad       (f_grad),
		.take         (take),
		.cfg          (cfg),
		.beta         (beta_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.gradient_out (gradient_out),
		.loss_total   (loss_total),
		.final_flag   (final_flag),
		.range_error  (range_error)
	);

endmodule

// ===== tb/gnll_loss_checker.sv =====
module gnll_loss_checker import gnll_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic signed [31:0]           mean_value,
	input  logic signed [31:0]           deviation_value,
	input  logic signed [31:0]           target_value,
	input  logic signed [31:0]           earlier_gradient,
	input  logic                         last_element,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic signed [31:0]           gradient_out,
	input  logic signed [47:0]           loss_total,
	input  logic                         final_flag,
	input  logic                         range_error,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [31:0]                  cfg_data,
	output int                           errors,
	output int                           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = FRACTION_BITS_DEF;
	localparam longint ACC_CAP = (longint'(1) <<< 47) - 1;
	localparam longint MAX64 = longint'(CAP64);

	typedef struct {
		logic signed [31:0] grad;
		logic signed [47:0] total;
		logic               fin;
		logic               err;
	} loss_result_t;

	loss_result_t expected_results[$];

	logic   grad_sel;
	longint beta;
	logic   prop_en;
	longint loss_sum;

	function automatic logic [63:0] mag_of(longint a);
		return a < 0 ? 64'(-a) : 64'(a);
	endfunction

	function automatic longint signed_mag(logic [127:0] m, bit neg, inout bit err);
		logic [63:0] v;
		v = m[63:0];
		if (m[127:63] != '0) begin
			err = 1'b1;
			v = CAP64;
		end
		return neg ? -longint'(v) : longint'(v);
	endfunction

	// magnitude product, shifted and truncated toward zero
	function automatic longint mul_trunc(longint a, longint b, int sh, inout bit err);
		logic [127:0] p;
		p = {64'd0, mag_of(a)} * {64'd0, mag_of(b)};
		p = p >> sh;
		return signed_mag(p, (a < 0) != (b < 0), err);
	endfunction

	function automatic longint div_trunc(longint a, logic [63:0] den, inout bit err);
		logic [127:0] n;
		n = {64'd0, mag_of(a)} << FB;
		n = n / {64'd0, den};
		return signed_mag(n, a < 0, err);
	endfunction

	function automatic longint clamp_add(longint a, longint b, longint cap, inout bit err);
		logic signed [65:0] s;
		s = a;
		s = s + b;
		if (s > cap) begin
			err = 1'b1;
			return cap;
		end
		if (s < -cap) begin
			err = 1'b1;
			return -cap;
		end
		return longint'(s);
	endfunction

	function automatic longint clamp_sub(longint a, longint b, longint cap, inout bit err);
		logic signed [65:0] s;
		s = a;
		s = s - b;
		if (s > cap) begin
			err = 1'b1;
			return cap;
		end
		if (s < -cap) begin
			err = 1'b1;
			return -cap;
		end
		return longint'(s);
	endfunction

	// log2 by repeated squaring of the normalized mantissa, then times ln2
	function automatic longint natural_log(logic [63:0] s, inout bit err);
		int p;
		logic [63:0] m;
		logic [127:0] sq;
		longint frac;
		longint l2;
		p = 0;
		frac = 0;
		for (int k = 0; k < 64; k++)
			if (s[k]) p = k;
		m = s << (62 - p);
		for (int k = 0; k < FB; k++) begin
			sq = {64'd0, m} * {64'd0, m};
			m = sq[125:62];
			frac = frac << 1;
			if (m[63]) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		l2 = (longint'(p) - FB) * (longint'(1) <<< FB) + frac;
		return mul_trunc(l2, longint'(LN2_Q32), 32, err);
	endfunction

	function automatic loss_result_t predict_element(longint mu, longint sg, longint x,
			longint g0, bit last);
		loss_result_t r;
		bit err;
		logic [63:0] us;
		longint d, q, term, half, grad, bp, inv, sq, r3;
		err = 1'b0;
		grad = 0;
		if (sg <= 0) begin
			sg = 1;
			err = 1'b1;
		end
		us = 64'(sg);
		d = clamp_sub(mu, x, MAX64, err);
		q = div_trunc(d, us, err);
		half = longint'((HALF_LN_2PI_Q32 + (64'd1 << (31 - FB))) >> (32 - FB));
		term = clamp_add(natural_log(us, err), half, MAX64, err);
		term = clamp_add(term, mul_trunc(q, q, FB + 1, err), MAX64, err);
		loss_sum = clamp_add(loss_sum, term, ACC_CAP, err);
		if (prop_en) begin
			bp = mul_trunc(beta, g0, FB, err);
			if (!grad_sel) begin
				grad = div_trunc(q, us, err);
				grad = clamp_add(grad, bp, MAX64, err);
			end else begin
				inv = div_trunc(longint'(1) <<< FB, us, err);
				sq = mul_trunc(q, q, FB, err);
				r3 = div_trunc(sq, us, err);
				grad = clamp_sub(clamp_add(inv, bp, MAX64, err), r3, MAX64, err);
			end
			if (grad > 64'sh7FFF_FFFF) begin
				grad = 64'sh7FFF_FFFF;
				err = 1'b1;
			end
			if (grad < -64'sh8000_0000) begin
				grad = -64'sh8000_0000;
				err = 1'b1;
			end
		end
		r.total = '0;
		if (last) begin
			r.total = loss_sum[47:0];
			loss_sum = 0;
		end
		r.grad = grad[31:0];
		r.fin = last;
		r.err = err;
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		loss_result_t want;
		if (!arst_n) begin
			grad_sel <= 1'b0;
			beta     = 0;
			prop_en  <= 1'b1;
			loss_sum = 0;
			errors   <= 0;
			expected_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GRAD_SEL: grad_sel <= cfg_data[0];
					REG_BETA:     beta = longint'(signed'(cfg_data));
					REG_PROP_EN:  prop_en <= cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_results.push_back(predict_element(mean_value, deviation_value,
					target_value, earlier_gradient, last_element));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					if (errors < 10)
						$display("unexpected result word: grad %h total %h", gradient_out,
							loss_total);
					errors <= errors + 1;
				end else begin
					want = expected_results.pop_front();
					if (want.grad !== gradient_out || want.total !== loss_total ||
							want.fin !== final_flag || want.err !== range_error) begin
						if (errors < 10)
							$display("mismatch: exp grad %h total %h fin %b err %b, got %h %h %b %b",
								want.grad, want.total, want.fin, want.err,
								gradient_out, loss_total, final_flag, range_error);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

// ===== tb/tb_gaussian_nll_loss_and_gradient_top.sv =====
module tb_gaussian_nll_loss_and_gradient_top import gnll_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_CYCLES = 1500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] mean_value = '0;
	logic signed [31:0] deviation_value = '0;
	logic signed [31:0] target_value = '0;
	logic signed [31:0] earlier_gradient = '0;
	logic last_element = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] gradient_out;
	logic signed [47:0] loss_total;
	logic final_flag;
	logic range_error;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_GRAD_SEL;
	logic [31:0] cfg_data = '0;
	int errors;
	int pending;
	bit hold_req = 1'b0;
	int burst_left = 0;

	gaussian_nll_loss_and_gradient_top i_dut (
		.clk, .arst_n, .in_valid, .in_stall, .mean_value, .deviation_value,
		.target_value, .earlier_gradient, .last_element, .out_valid, .out_stall,
		.gradient_out, .loss_total, .final_flag, .range_error, .cfg_we, .cfg_index,
		.cfg_data
	);

	gnll_loss_checker i_loss_checker (
		.clk, .arst_n, .in_valid, .in_stall, .mean_value, .deviation_value,
		.target_value, .earlier_gradient, .last_element, .out_valid, .out_stall,
		.gradient_out, .loss_total, .final_flag, .range_error, .cfg_we, .cfg_index,
		.cfg_data, .errors, .pending
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver: stall density is drawn from four random modes, with one long hold on request
	initial begin
		int mode;
		int cyc;
		mode = 0;
		cyc = 0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (cyc % 256 == 0)
					mode = $urandom_range(0, 3);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 9) < 6);
					default: out_stall <= ($urandom_range(0, 9) != 0);
				endcase
				cyc++;
				@(posedge clk);
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic send_element(logic signed [31:0] mu, logic signed [31:0] sg,
			logic signed [31:0] x, logic signed [31:0] g, logic last);
		logic st;
		if (burst_left == 0) begin
			int gap;
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 15);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		mean_value <= mu;
		deviation_value <= sg;
		target_value <= x;
		earlier_gradient <= g;
		last_element <= last;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			st = in_stall;
			@(posedge clk);
		end while (st);
	endtask

	// drop valid in the step of the last acceptance, then wait for every result
	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [31:0] pick_deviation();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return $urandom;
		if (r == 1) return -$urandom_range(0, 32'h0002_0000);
		if (r < 5) return $urandom_range(1, 255);
		return $urandom_range(32'h1000, 32'h80000);
	endfunction

	function automatic logic signed [31:0] pick_value();
		if ($urandom_range(0, 7) == 0) return $urandom;
		return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
	endfunction

	initial begin
		logic        sel_list  [7] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
		logic [31:0] beta_list [7];
		logic        prop_list [7] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
		beta_list = '{32'h0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, $urandom,
			32'hFFFF_8000, $urandom};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset: mean gradient, no blending
		send_element(32'sh10000, 32'sh10000, 32'sh0, 32'sh0, 1'b0);
		send_element(32'sh0, 32'sh0, 32'sh10000, 32'sh10000, 1'b0);
		send_element(32'sh8000, -32'sh10000, 32'sh0, 32'sh0, 1'b0);
		send_element(32'sh0, 32'sh8000_0000, 32'sh100, 32'sh0, 1'b0);
		send_element(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
		send_element(32'sh7FFF_FFFF, 32'sh1, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
		send_element(32'sh8000_0000, 32'sh1, 32'sh7FFF_FFFF, 32'sh0, 1'b1);
		send_element(32'sh8000_0000, 32'sh10000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
		send_element(32'sh12345, 32'sh8000, -32'sh6789, 32'sh8000_0000, 1'b0);
		send_element(32'sh7FFF_FFFF, 32'sh2, 32'sh7FFF_FFFF, 32'sh1234, 1'b1);
		send_element(32'shFFFF_FFFF, 32'shFF, 32'sh0, 32'shFFFF_FFFF, 1'b1);

		for (int ph = 0; ph < 7; ph++) begin
			drain_results();
			if (ph == 6)
				write_reg(REG_SPARE, $urandom);
			write_reg(REG_GRAD_SEL, {31'($urandom), sel_list[ph]});
			write_reg(REG_BETA, beta_list[ph]);
			write_reg(REG_PROP_EN, {31'($urandom), prop_list[ph]});
			if (ph == 2)
				hold_req = 1'b1;
			send_element(32'sh7FFF_FFFF, 32'sh1, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
			send_element(32'sh1000, 32'sh0, -32'sh1000, 32'sh8000_0000, 1'b0);
			send_element(-32'sh30000, 32'sh7FFF_FFFF, 32'sh20000, 32'sh10000, 1'b1);
			for (int n = 0; n < 62; n++)
				send_element(pick_value(), pick_deviation(), pick_value(),
					($urandom_range(0, 1) != 0) ? $urandom : pick_value(),
					$urandom_range(0, 7) == 0);
			send_element(pick_value(), pick_deviation(), pick_value(), pick_value(), 1'b1);
		end

		drain_results();
		repeat (600) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
